// ----- hw/rtl/p2rf_pkg.sv -----
package p2rf_pkg;

  // Request codes carried on req_type.
  typedef enum logic [1:0] {
    REQ_FILL   = 2'd0,
    REQ_INVERT = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  // Configuration register indexes.
  localparam logic [2:0] CFG_CLIP_LEFT   = 3'd0;
  localparam logic [2:0] CFG_CLIP_RIGHT  = 3'd1;
  localparam logic [2:0] CFG_CLIP_TOP    = 3'd2;
  localparam logic [2:0] CFG_CLIP_BOTTOM = 3'd3;
  localparam logic [2:0] CFG_OFFSET_X    = 3'd4;
  localparam logic [2:0] CFG_OFFSET_Y    = 3'd5;

  // Signed coordinate wide enough for position + offset + size.
  localparam int CW = 16;
  typedef logic signed [CW-1:0] coord_t;

  localparam logic [7:0] MASK_ALL = 8'hff;

  function automatic coord_t smax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t smin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  // Colours 0..3 are scaled by 5, then the low nibble is repeated in both
  // halves so that even pixels take bits 3:2 and odd pixels bits 1:0.
  function automatic logic [7:0] expand_colour(input logic [7:0] colour);
    logic [7:0] c;
    c = (colour <= 8'd3) ? colour * 8'd5 : colour;
    return {c[3:0], c[3:0]};
  endfunction

endpackage

// ----- hw/rtl/packed_2bpp_rect_fill_invert.sv -----
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-------------------------------------------
// request   | req_valid / req_stall            | req_type pos_x pos_y rect_width
//           |                                  | rect_height colour
// result    | res_valid / res_stall            | read_data drew
// config    | cfg_we (no wait)                 | cfg_index cfg_data
//
// A fill or invert is captured, offset and clipped, then walks the N store bytes of the
// clipped rectangle (one read-modify-write per cycle) before res_valid is raised.
// A read skips the clip and the walk, and a command that draws nothing skips the walk.
// The next request can be taken in the cycle after the result is loaded; a result held
// by res_stall delays the load.
// Reset (rst, synchronous) restores the clip window and offsets and empties the result
// register; the frame store itself is not cleared.
module packed_2bpp_rect_fill_invert #(
  parameter int LINE_BYTES = 128,
  parameter int LINE_COUNT = 256
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          req_type,
  input  logic signed [11:0]  pos_x,
  input  logic signed [11:0]  pos_y,
  input  logic signed [11:0]  rect_width,
  input  logic signed [11:0]  rect_height,
  input  logic [7:0]          colour,
  // result channel
  output logic                res_valid,
  input  logic                res_stall,
  output logic [7:0]          read_data,
  output logic                drew,
  // configuration port
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [11:0]         cfg_data
);
  import p2rf_pkg::*;

  // Store geometry. Each index is exactly as wide as its depth needs.
  localparam int DEPTH = LINE_BYTES * LINE_COUNT;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int LW = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
  localparam coord_t X_LIM = coord_t'(4 * LINE_BYTES);
  localparam coord_t Y_LIM = coord_t'(LINE_COUNT);

  typedef enum logic [3:0] {
    S_IDLE, S_CALC, S_CLIP, S_PREP, S_WALK, S_DRAIN, S_RDREQ, S_RDWAIT, S_FIN
  } state_t;

  state_t state;

  // Configuration registers.
  logic [9:0]         clip_left, clip_right;
  logic [8:0]         clip_top, clip_bottom;
  logic signed [11:0] offset_x, offset_y;

  // Captured request.
  logic [1:0]         req;
  logic signed [11:0] px, py, rw, rh;
  logic [7:0]         col;

  // Offset rectangle, then its clipped bounds.
  coord_t xs, ys, xe, ye;
  coord_t x0, y0, x1, y1;
  logic   draw_ok;

  // Walk state.
  logic [LW-1:0] row, row_last;
  logic [BW-1:0] bx, bx_first, bx_last;
  logic [7:0]    first_mask, last_mask;
  logic          is_fill;

  // Read request state.
  logic          rd_ok;
  logic [AW-1:0] rd_addr;

  // Pending write of the byte whose read was issued last cycle.
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic [7:0]    pend_mask;

  logic [7:0]    res_byte;
  logic          res_drew;

  // Frame store with a registered read port.
  logic [7:0]    mem [DEPTH];
  logic [7:0]    mem_q;
  logic [AW-1:0] raddr, walk_addr;
  logic [7:0]    wdata, walk_mask;
  coord_t        x_last;

  assign req_stall = (state != S_IDLE);

  assign walk_addr = AW'(row) * AW'(LINE_BYTES) + AW'(bx);
  assign raddr     = (state == S_WALK) ? walk_addr : rd_addr;
  assign walk_mask = ((bx == bx_first) ? first_mask : MASK_ALL) &
                     ((bx == bx_last) ? last_mask : MASK_ALL);
  assign wdata     = is_fill ? ((mem_q & ~pend_mask) | (col & pend_mask))
                             : (mem_q ^ pend_mask);
  assign x_last    = x1 - coord_t'(1);

  always_ff @(posedge clk) begin
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      mem[pend_addr] <= wdata;
    end
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_left   <= 10'd0;
      clip_right  <= 10'd512;
      clip_top    <= 9'd0;
      clip_bottom <= 9'd256;
      offset_x    <= 12'sd0;
      offset_y    <= 12'sd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CLIP_LEFT:   clip_left   <= cfg_data[9:0];
        CFG_CLIP_RIGHT:  clip_right  <= cfg_data[9:0];
        CFG_CLIP_TOP:    clip_top    <= cfg_data[8:0];
        CFG_CLIP_BOTTOM: clip_bottom <= cfg_data[8:0];
        CFG_OFFSET_X:    offset_x    <= cfg_data;
        CFG_OFFSET_Y:    offset_y    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: capture, offset, clip, walk the bytes (or read one byte), then hand the
  // result to the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      pend <= (state == S_WALK);
      // The output register loads in S_FIN once it is free, and empties when
      // the receiver takes the result.
      if ((state == S_FIN) && (!res_valid || !res_stall)) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            req      <= req_type;
            px       <= pos_x;
            py       <= pos_y;
            rw       <= rect_width;
            rh       <= rect_height;
            col      <= expand_colour(colour);
            res_byte <= 8'd0;
            res_drew <= 1'b0;
            state    <= S_CALC;
          end
        end
        S_CALC: begin
          xs      <= coord_t'(px) + coord_t'(offset_x);
          ys      <= coord_t'(py) + coord_t'(offset_y);
          xe      <= coord_t'(px) + coord_t'(offset_x) + coord_t'(rw);
          ye      <= coord_t'(py) + coord_t'(offset_y) + coord_t'(rh);
          draw_ok <= ((req == REQ_FILL) || (req == REQ_INVERT)) &&
                     (rw > 12'sd0) && (rh > 12'sd0);
          is_fill <= (req == REQ_FILL);
          rd_ok   <= (px >= 12'sd0) && (py >= 12'sd0) &&
                     (coord_t'(px) < X_LIM) && (coord_t'(py) < Y_LIM);
          rd_addr <= AW'(py[LW-1:0]) * AW'(LINE_BYTES) + AW'(px[BW+1:2]);
          state   <= (req == REQ_READ) ? S_RDREQ : S_CLIP;
        end
        S_CLIP: begin
          x0    <= smax(smax(xs, coord_t'({1'b0, clip_left})), coord_t'(0));
          y0    <= smax(smax(ys, coord_t'({1'b0, clip_top})), coord_t'(0));
          x1    <= smin(smin(xe, coord_t'({1'b0, clip_right})), X_LIM);
          y1    <= smin(smin(ye, coord_t'({1'b0, clip_bottom})), Y_LIM);
          state <= S_PREP;
        end
        S_PREP: begin
          // Both corners are inside the surface once the window is not empty.
          if (draw_ok && (x0 < x1) && (y0 < y1)) begin
            res_drew   <= 1'b1;
            row        <= y0[LW-1:0];
            row_last   <= LW'(y1 - coord_t'(1));
            bx         <= x0[BW+1:2];
            bx_first   <= x0[BW+1:2];
            bx_last    <= x_last[BW+1:2];
            first_mask <= MASK_ALL >> {x0[1:0], 1'b0};
            last_mask  <= MASK_ALL << {~x_last[1:0], 1'b0};
            state      <= S_WALK;
          end else begin
            state <= S_FIN;
          end
        end
        S_WALK: begin
          pend_addr <= walk_addr;
          pend_mask <= walk_mask;
          if (bx == bx_last) begin
            bx <= bx_first;
            if (row == row_last) begin
              state <= S_DRAIN;
            end else begin
              row <= row + LW'(1);
            end
          end else begin
            bx <= bx + BW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FIN;
        end
        S_RDREQ: begin
          state <= S_RDWAIT;
        end
        S_RDWAIT: begin
          res_byte <= rd_ok ? mem_q : 8'd0;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (!res_valid || !res_stall) begin
            read_data <= res_byte;
            drew      <= res_drew;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/p2rf_checker.sv -----
module p2rf_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_stall,
  input logic       res_valid,
  input logic       res_stall,
  input logic [7:0] read_data,
  input logic       drew
);
  import p2rf_pkg::*;

  // A held result keeps its value.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(read_data) && $stable(drew))
    else $error("result changed while stalled");

  // Every accepted request makes the block busy in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken without the block going busy");

  // A result is either a read byte or a drawing flag, never both.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(drew && (read_data != 8'd0)))
    else $error("drew set on a result that carries read data");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

endmodule

bind packed_2bpp_rect_fill_invert p2rf_checker u_p2rf_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .read_data (read_data),
  .drew      (drew)
);

// ----- sim/packed_2bpp_rect_fill_invert_checker.sv -----
`timescale 1ns / 1ps

// Watches the request, result and configuration channels, keeps its own copy of the
// frame store and the clip/offset registers, and compares every result with the
// oldest outstanding prediction.
module packed_2bpp_rect_fill_invert_checker #(
  parameter int LINE_BYTES = 128,
  parameter int LINE_COUNT = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic signed [11:0] pos_x,
  input  logic signed [11:0] pos_y,
  input  logic signed [11:0] rect_width,
  input  logic signed [11:0] rect_height,
  input  logic [7:0]         colour,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic [7:0]         read_data,
  input  logic               drew,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [11:0]        cfg_data,
  output int                 mismatches,
  output int                 pending
);
  import p2rf_pkg::*;

  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [7:0] data;
    logic       drew;
  } reply_t;

  logic [7:0] frame_copy [LINE_BYTES*LINE_COUNT];
  int         clip_l, clip_r, clip_t, clip_b, off_x, off_y;
  reply_t     pending_replies [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  // Applies one request to the local frame copy and works out its reply.
  task automatic render_command(input logic [1:0] kind, input int px, input int py,
                                input int w, input int h, input logic [7:0] col,
                                output reply_t r);
    int         x0, y0, x1, y1, row, column, addr, cval;
    logic [7:0] mask, fill_byte;
    r.data = '0;
    r.drew = 1'b0;
    if (kind == REQ_READ) begin
      if (px >= 0 && py >= 0 && px < 4*LINE_BYTES && py < LINE_COUNT) begin
        r.data = frame_copy[py*LINE_BYTES + px/4];
      end
    end else if ((kind == REQ_FILL || kind == REQ_INVERT) && w > 0 && h > 0) begin
      x0 = px + off_x;
      if (x0 < clip_l) x0 = clip_l;
      if (x0 < 0) x0 = 0;
      y0 = py + off_y;
      if (y0 < clip_t) y0 = clip_t;
      if (y0 < 0) y0 = 0;
      x1 = px + off_x + w;
      if (x1 > clip_r) x1 = clip_r;
      if (x1 > 4*LINE_BYTES) x1 = 4*LINE_BYTES;
      y1 = py + off_y + h;
      if (y1 > clip_b) y1 = clip_b;
      if (y1 > LINE_COUNT) y1 = LINE_COUNT;
      if (x0 < x1 && y0 < y1) begin
        cval = col;
        if (cval <= 3) cval = cval * 5;
        fill_byte = {2{cval[3:0]}};
        r.drew = 1'b1;
        for (row = y0; row < y1; row++) begin
          for (column = x0; column < x1; column++) begin
            addr = row*LINE_BYTES + column/4;
            mask = 8'hc0 >> (2*(column % 4));
            if (kind == REQ_FILL) begin
              frame_copy[addr] = (frame_copy[addr] & ~mask) | (fill_byte & mask);
            end else begin
              frame_copy[addr] = frame_copy[addr] ^ mask;
            end
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin : watch
    reply_t want;
    if (rst) begin
      clip_l = 0;
      clip_r = 512;
      clip_t = 0;
      clip_b = 256;
      off_x  = 0;
      off_y  = 0;
      pending_replies.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CLIP_LEFT:   clip_l = cfg_data[9:0];
          CFG_CLIP_RIGHT:  clip_r = cfg_data[9:0];
          CFG_CLIP_TOP:    clip_t = cfg_data[8:0];
          CFG_CLIP_BOTTOM: clip_b = cfg_data[8:0];
          CFG_OFFSET_X:    off_x  = int'($signed(cfg_data));
          CFG_OFFSET_Y:    off_y  = int'($signed(cfg_data));
          default: ;
        endcase
      end
      // A result taken at this edge belongs to an earlier request, so it is
      // matched before a request taken at the same edge is queued.
      if (res_valid && !res_stall) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("result with no request outstanding: read_data=%h drew=%b",
                                    read_data, drew));
        end else begin
          want = pending_replies.pop_front();
          if (read_data !== want.data) begin
            report_mismatch($sformatf("read_data %h, expected %h", read_data, want.data));
          end
          if (drew !== want.drew) begin
            report_mismatch($sformatf("drew %b, expected %b", drew, want.drew));
          end
        end
      end
      if (req_valid && !req_stall) begin
        render_command(req_type, pos_x, pos_y, rect_width, rect_height, colour, want);
        pending_replies.push_back(want);
      end
    end
    pending = pending_replies.size();
  end

endmodule

// ----- sim/packed_2bpp_rect_fill_invert_tb.sv -----
`timescale 1ns / 1ps

// Testbench top for the packed 2bpp rectangle fill/invert engine.
//
// This module only generates stimulus and gives the verdict. All prediction and
// comparison happens in the checker instance, which watches the same wires as the
// block and reports how many mismatches it saw and how many replies are still owed.
//
// The frame store comes up undefined, so the very first request is a fill that
// covers the whole surface. After that every byte holds a known value and reads
// may go anywhere.
module packed_2bpp_rect_fill_invert_tb;
  import p2rf_pkg::*;

  localparam int LINE_BYTES = 128;
  localparam int LINE_COUNT = 256;
  // Longest gap the sender puts between bursts of requests.
  localparam int MAX_GAP = 12;
  // One long stretch in which the result side refuses everything.
  localparam int LONG_HOLD = 400;
  // A full-surface command walks every byte once; allow that several times over,
  // plus the long hold and the sender's gap, before calling the run hung.
  localparam int QUIET_LIMIT = 4 * (LINE_BYTES*LINE_COUNT + LONG_HOLD + MAX_GAP + 16);
  // Cycles allowed after the last reply for anything stray to show up.
  localparam int DRAIN_CYCLES = 20;

  typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               req_valid   = 1'b0;
  logic               req_stall;
  logic [1:0]         req_type    = REQ_FILL;
  logic signed [11:0] pos_x       = '0;
  logic signed [11:0] pos_y       = '0;
  logic signed [11:0] rect_width  = '0;
  logic signed [11:0] rect_height = '0;
  logic [7:0]         colour      = '0;
  logic               res_valid;
  logic               res_stall   = 1'b0;
  logic [7:0]         read_data;
  logic               drew;
  logic               cfg_we      = 1'b0;
  logic [2:0]         cfg_index   = CFG_CLIP_LEFT;
  logic [11:0]        cfg_data    = '0;

  int mismatches;
  int pending;
  int quiet_cycles = 0;
  int burst_left   = 0;
  bit hold_now     = 1'b0;

  // Current register settings as seen by the stimulus, used to aim rectangles
  // at the visible window.
  int win_l, win_r, win_t, win_b, cur_off_x, cur_off_y;

  always #10 clk = ~clk;

  packed_2bpp_rect_fill_invert #(
    .LINE_BYTES(LINE_BYTES),
    .LINE_COUNT(LINE_COUNT)
  ) dut (.*);

  packed_2bpp_rect_fill_invert_checker #(
    .LINE_BYTES(LINE_BYTES),
    .LINE_COUNT(LINE_COUNT)
  ) frame_check (.*);

  // The watchdog counts cycles in which neither channel moved a request or a result.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("packed_2bpp_rect_fill_invert_tb: FAIL");
    $finish;
  end

  // The result side stalls on a pattern of its own that it picks anew at random:
  // no stalls at all, light or heavy random stalls, or a fixed rhythm.
  // When the main sequence asks for it, it holds off completely for one long stretch
  // (LONG_HOLD) so the block fills up and has to push back on the request side.
  initial begin : receiver
    flow_t mode;
    int    left_in_mode;
    int    hold_left;
    bit    hold_taken;
    mode         = FLOW_FREE;
    left_in_mode = 0;
    hold_left    = 0;
    hold_taken   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_now && !hold_taken) begin
        hold_left  = LONG_HOLD;
        hold_taken = 1'b1;
      end
      if (left_in_mode == 0) begin
        mode         = flow_t'($urandom_range(0, 3));
        left_in_mode = $urandom_range(20, 120);
      end
      left_in_mode--;
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        case (mode)
          FLOW_FREE:  res_stall <= 1'b0;
          FLOW_LIGHT: res_stall <= ($urandom_range(0, 99) < 30);
          FLOW_HEAVY: res_stall <= ($urandom_range(0, 99) < 75);
          default:    res_stall <= (left_in_mode % 4 == 0);
        endcase
      end
    end
  end

  // Saturates a coordinate into the 12-bit signed field.
  function automatic logic signed [11:0] to_field(input int v);
    return 12'(v < -2048 ? -2048 : (v > 2047 ? 2047 : v));
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // Offers one request and returns at the falling edge after it was taken.
  // Requests go out in bursts; between bursts the sender sometimes idles for a
  // random number of cycles, and sometimes starts the next burst right away.
  task automatic send_request(input req_t kind, input int x, input int y,
                              input int w, input int h, input logic [7:0] col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, MAX_GAP);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_type    <= kind;
    pos_x       <= to_field(x);
    pos_y       <= to_field(y);
    rect_width  <= to_field(w);
    rect_height <= to_field(h);
    colour      <= col;
    req_valid   <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering requests and waits until every reply has come back, then gives
  // the block a few more cycles before the registers are touched.
  task automatic wait_until_drained();
    req_valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(negedge clk);
  endtask

  // Writes all six registers back to back; only called while the block is idle.
  task automatic write_config(input int left, input int right, input int top,
                              input int bottom, input int ox, input int oy);
    logic [2:0] reg_index [6];
    int         reg_value [6];
    reg_index = '{CFG_CLIP_LEFT, CFG_CLIP_RIGHT, CFG_CLIP_TOP,
                  CFG_CLIP_BOTTOM, CFG_OFFSET_X, CFG_OFFSET_Y};
    reg_value = '{left, right, top, bottom, ox, oy};
    for (int i = 0; i < 6; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_index[i];
      cfg_data  <= 12'(reg_value[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
    win_l     = left;
    win_r     = right;
    win_t     = top;
    win_b     = bottom;
    cur_off_x = ox;
    cur_off_y = oy;
  endtask

  // One random request. Most are rectangles aimed at the clip window after the
  // offset is taken out, with mostly small sizes plus one-pixel lines and a few
  // empty shapes. About a quarter are reads, and the rest is noise with every
  // field drawn from its full range.
  task automatic send_random_command();
    int         pick, shape, lo_x, hi_x, lo_y, hi_y, tx, ty, w, h;
    logic [7:0] col;
    req_t       kind;
    pick = $urandom_range(0, 99);
    col  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
    if (pick < 65) begin
      kind  = (pick < 40) ? REQ_FILL : REQ_INVERT;
      lo_x  = ((win_l < win_r) ? win_l : win_r) - 10;
      hi_x  = ((win_l < win_r) ? win_r : win_l) + 10;
      lo_y  = ((win_t < win_b) ? win_t : win_b) - 10;
      hi_y  = ((win_t < win_b) ? win_b : win_t) + 10;
      tx    = lo_x + $urandom_range(0, hi_x - lo_x);
      ty    = lo_y + $urandom_range(0, hi_y - lo_y);
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
        w = $urandom_range(1, 200);
        h = 1;
      end else if (shape == 1) begin
        w = 1;
        h = $urandom_range(1, 100);
      end else if (shape == 2) begin
        // Not-positive width or height: nothing may be drawn.
        w = -int'($urandom_range(0, 2048));
        h = $urandom_range(1, 20);
        if ($urandom_range(0, 1) == 1) begin
          h = w;
          w = $urandom_range(1, 20);
        end
      end else begin
        w = $urandom_range(1, 40);
        h = $urandom_range(1, 24);
      end
      send_request(kind, tx - cur_off_x, ty - cur_off_y, w, h, col);
    end else if (pick < 92) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(REQ_READ, any_coord(), any_coord(), any_coord(), any_coord(), col);
      end else begin
        send_request(REQ_READ, $urandom_range(0, 4*LINE_BYTES - 1),
                     $urandom_range(0, LINE_COUNT - 1), any_coord(), any_coord(), col);
      end
    end else begin
      kind = req_t'($urandom_range(0, 3));
      w    = any_coord();
      h    = any_coord();
      // Keep noise rectangles from covering the whole surface too often.
      if (w > 64 && h > 64) h = $urandom_range(1, 4);
      send_request(kind, any_coord(), any_coord(), w, h, 8'($urandom()));
    end
  endtask

  initial begin : stimulus
    int l0, l1, t0, t1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset values, written explicitly so every register sees a write.
    write_config(0, 4*LINE_BYTES, 0, LINE_COUNT, 0, 0);

    // Directed part. The first fill starts off the surface and is far too large,
    // so it is clipped to exactly the whole store and defines every byte.
    send_request(REQ_FILL,   -5,    -7,   2047,  2047,  8'd1);
    send_request(REQ_READ,    0,     0,   0,     0,     8'd0);
    send_request(REQ_READ,    511,   255, 0,     0,     8'd0);
    // Colours 0 to 3 are scaled by 5; larger values use their low nibble, which
    // dithers between even and odd columns. Start columns avoid byte alignment.
    send_request(REQ_FILL,    3,     3,   6,     2,     8'd0);
    send_request(REQ_FILL,    1,     10,  5,     3,     8'd2);
    send_request(REQ_FILL,    9,     20,  7,     2,     8'd3);
    send_request(REQ_FILL,    30,    5,   11,    4,     8'd4);
    send_request(REQ_FILL,    50,    7,   9,     3,     8'd15);
    send_request(REQ_FILL,    70,    2,   13,    5,     8'hff);
    send_request(REQ_FILL,    90,    40,  6,     6,     8'ha6);
    // Empty rectangles: zero width, negative height, most negative width.
    send_request(REQ_FILL,    10,    10,  0,     5,     8'd7);
    send_request(REQ_INVERT,  10,    10,  5,     -1,    8'd0);
    send_request(REQ_FILL,    0,     0,   -2048, 2047,  8'd9);
    // Lines: a full-height vertical line, the whole top line inverted, and a
    // horizontal line running off the right edge of the surface.
    send_request(REQ_FILL,    100,   0,   1,     256,   8'd7);
    send_request(REQ_INVERT,  0,     0,   512,   1,     8'd0);
    send_request(REQ_INVERT,  200,   255, 2047,  1,     8'd0);
    // Invert hanging off the top-left corner.
    send_request(REQ_INVERT,  -3,    -2,  8,     4,     8'd0);
    // The unused selector does nothing.
    send_request(REQ_NONE,    12,    12,  30,    30,    8'd5);
    // Reads outside the store return zero; reads inside check the work above.
    send_request(REQ_READ,    -1,    0,   0,     0,     8'd0);
    send_request(REQ_READ,    512,   0,   0,     0,     8'd0);
    send_request(REQ_READ,    0,     256, 0,     0,     8'd0);
    send_request(REQ_READ,    2047,  -2048, 0,   0,     8'd0);
    send_request(REQ_READ,    3,     3,   0,     0,     8'd0);
    send_request(REQ_READ,    100,   100, 0,     0,     8'd0);
    // Starts beyond the far corner, so clips to nothing.
    send_request(REQ_INVERT,  2047,  2047, 2047, 2047,  8'd0);
    repeat (100) send_random_command();
    wait_until_drained();

    // A clipped window with small offsets. The result side holds off for a long
    // stretch while requests keep coming, so the block backs up.
    write_config(37, 301, 11, 200, 5, -3);
    hold_now = 1'b1;
    repeat (80) send_random_command();
    wait_until_drained();

    // Inverted clip window (left past right, top past bottom) with extreme
    // offsets: nothing can be drawn, but reads still see the store.
    write_config(512, 0, 256, 0, -2048, 2047);
    repeat (15) send_random_command();
    wait_until_drained();

    // Full window with the opposite offset extremes.
    write_config(0, 512, 0, 256, 2047, -2048);
    repeat (15) send_random_command();
    wait_until_drained();

    // A window of just the bottom-right pixel.
    write_config(511, 512, 255, 256, -1, 1);
    repeat (20) send_random_command();
    wait_until_drained();

    // Random ordered windows with moderate offsets.
    repeat (3) begin
      l0 = $urandom_range(0, 512);
      l1 = $urandom_range(0, 512);
      t0 = $urandom_range(0, 256);
      t1 = $urandom_range(0, 256);
      write_config((l0 < l1) ? l0 : l1, (l0 < l1) ? l1 : l0,
                   (t0 < t1) ? t0 : t1, (t0 < t1) ? t1 : t0,
                   int'($urandom_range(0, 200)) - 100, int'($urandom_range(0, 200)) - 100);
      repeat (50) send_random_command();
      wait_until_drained();
    end

    // Give any stray result a chance to show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("packed_2bpp_rect_fill_invert_tb: PASS");
    end else begin
      $display("packed_2bpp_rect_fill_invert_tb: FAIL");
    end
    $finish;
  end

endmodule
